### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define SCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define SCT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/sct_pkg.sv
`timescale 1ns / 1ps
package sct_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_end;
	} sct_in_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [3:0] token_type;
		logic [1:0] part_type;
		logic [1:0] quote;
		logic       part_start;
		logic [7:0] value;
		logic       last;
	} sct_out_t;

	typedef sct_out_t [2:0] sct_res3_t;

	typedef enum logic [2:0] {
		LEX_IDLE, LEX_OP, LEX_WORD, LEX_ESC, LEX_VAR, LEX_VCLOSE, LEX_TILDE
	} sct_lex_t;

	localparam logic [1:0] Q_NONE = 2'd0;
	localparam logic [1:0] Q_SINGLE = 2'd1;
	localparam logic [1:0] Q_DOUBLE = 2'd2;

	localparam logic [1:0] P_LIT = 2'd0;
	localparam logic [1:0] P_VAR = 2'd1;
	localparam logic [1:0] P_TILDE = 2'd2;
	localparam logic [1:0] P_GLOB = 2'd3;

	localparam logic [1:0] EV_CHAR = 2'd0;
	localparam logic [1:0] EV_TOKEN = 2'd1;
	localparam logic [1:0] EV_ERROR = 2'd2;

	localparam logic [3:0] T_WORD = 4'd0;
	localparam logic [3:0] T_FD = 4'd1;
	localparam logic [3:0] T_PIPE = 4'd2;
	localparam logic [3:0] T_OR = 4'd3;
	localparam logic [3:0] T_BG = 4'd4;
	localparam logic [3:0] T_AND = 4'd5;
	localparam logic [3:0] T_OUT = 4'd6;
	localparam logic [3:0] T_APPEND = 4'd7;
	localparam logic [3:0] T_IN = 4'd8;
	localparam logic [3:0] T_SEMI = 4'd9;
	localparam logic [3:0] T_EOF = 4'd10;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_PIPE = 2'd1;
	localparam logic [1:0] OP_AMP = 2'd2;
	localparam logic [1:0] OP_GT = 2'd3;

	localparam logic [1:0] FD_START = 2'd0;
	localparam logic [1:0] FD_SIGN = 2'd1;
	localparam logic [1:0] FD_DIGITS = 2'd2;
	localparam logic [1:0] FD_FAIL = 2'd3;

	localparam logic [7:0] C_BSLASH = 8'h5C;
	localparam logic [7:0] C_DOLLAR = 8'h24;
	localparam logic [7:0] C_TILDE = 8'h7E;
	localparam logic [7:0] C_LBRACE = 8'h7B;
	localparam logic [7:0] C_RBRACE = 8'h7D;
	localparam logic [7:0] C_UNDER = 8'h5F;
	localparam logic [7:0] C_BAR = 8'h7C;
	localparam logic [7:0] C_AMP = 8'h26;
	localparam logic [7:0] C_GT = 8'h3E;
	localparam logic [7:0] C_LT = 8'h3C;
	localparam logic [7:0] C_SEMI = 8'h3B;
	localparam logic [7:0] C_SQUOTE = 8'h27;
	localparam logic [7:0] C_DQUOTE = 8'h22;
	localparam logic [7:0] C_STAR = 8'h2A;
	localparam logic [7:0] C_QMARK = 8'h3F;
	localparam logic [7:0] C_BANG = 8'h21;
	localparam logic [7:0] C_MINUS = 8'h2D;
	localparam logic [7:0] C_PLUS = 8'h2B;

	typedef struct packed {
		sct_lex_t   lex_mode;
		logic [1:0] quote_mode;
		logic [1:0] pending_op;
		logic       brace_open;
		logic       name_seen;
		logic [1:0] fd_check;
		logic       part_open;
		logic       in_word;
	} sct_state_t;

	localparam sct_state_t STATE_RESET = '{LEX_IDLE, Q_NONE, OP_NONE, 1'b0, 1'b0,
		FD_START, 1'b0, 1'b0};

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_name(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
			|| c == C_UNDER;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_meta(input logic [7:0] c);
		return c == C_BAR || c == C_AMP || c == C_SEMI || c == C_LT || c == C_GT;
	endfunction

	function automatic logic is_special(input logic [7:0] c);
		return c == C_DOLLAR || c == C_QMARK || c == C_BANG || c == C_MINUS;
	endfunction

	function automatic logic [7:0] translate(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			8'h6E: r = 8'd10;
			8'h74: r = 8'd9;
			8'h72: r = 8'd13;
			8'h61: r = 8'd7;
			8'h62: r = 8'd8;
			8'h66: r = 8'd12;
			8'h76: r = 8'd11;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic sct_out_t mk(input logic [1:0] ev, input logic [3:0] tok,
		input logic [1:0] pt, input logic [1:0] q, input logic ps, input logic [7:0] val);
		sct_out_t o;
		o.event_res = ev;
		o.token_type = tok;
		o.part_type = pt;
		o.quote = q;
		o.part_start = ps;
		o.value = val;
		o.last = 1'b0;
		return o;
	endfunction

	function automatic sct_res3_t put(input sct_res3_t r, input logic [1:0] n,
		input sct_out_t o);
		sct_res3_t t;
		t = r;
		if (n != 2'd3) begin
			t[n] = o;
		end
		return t;
	endfunction

	function automatic logic [1:0] bump(input logic [1:0] n);
		return (n == 2'd3) ? n : n + 2'd1;
	endfunction

	function automatic logic [3:0] word_tok(input logic [1:0] fd);
		return (fd == FD_DIGITS) ? T_FD : T_WORD;
	endfunction

endpackage

### sv/sct_step.sv
`timescale 1ns / 1ps
module sct_step (
	input  sct_pkg::sct_in_t    item,
	input  sct_pkg::sct_state_t cur,
	output sct_pkg::sct_state_t nxt,
	output sct_pkg::sct_res3_t  res,
	output logic [1:0]          count
);

	always_comb begin
		sct_pkg::sct_state_t s;
		sct_pkg::sct_res3_t r;
		logic [1:0] n;
		logic [7:0] c;
		logic eol;
		logic done;
		logic do_word;
		logic [1:0] op;
		logic [7:0] opc;
		s = cur;
		r = '0;
		n = 2'd0;
		c = item.ch;
		eol = item.is_end || c == 8'h00;
		done = 1'b0;
		do_word = 1'b0;
		op = cur.pending_op;
		unique case (op)
			sct_pkg::OP_PIPE: opc = sct_pkg::C_BAR;
			sct_pkg::OP_AMP: opc = sct_pkg::C_AMP;
			sct_pkg::OP_GT: opc = sct_pkg::C_GT;
			default: opc = 8'h00;
		endcase

		unique case (cur.lex_mode)
			sct_pkg::LEX_OP: begin
				s.lex_mode = sct_pkg::LEX_IDLE;
				s.pending_op = sct_pkg::OP_NONE;
				if (!eol && c == opc) begin
					r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_TOKEN,
						{op, 1'b1} == 3'd1 ? 4'd0 : {1'b0, op, 1'b1}, 2'd0, 2'd0, 1'b0, 8'd0));
					n = sct_pkg::bump(n);
					done = 1'b1;
				end else begin
					r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_TOKEN,
						(op == sct_pkg::OP_NONE) ? 4'd0 : {1'b0, op, 1'b0}, 2'd0, 2'd0, 1'b0, 8'd0));
					n = sct_pkg::bump(n);
				end
			end
			sct_pkg::LEX_ESC: begin
				s.lex_mode = sct_pkg::LEX_WORD;
				if (!eol) begin
					r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_CHAR, sct_pkg::T_WORD,
						sct_pkg::P_LIT, s.quote_mode, !s.part_open, sct_pkg::translate(c)));
					n = sct_pkg::bump(n);
					s.part_open = 1'b1;
					done = 1'b1;
				end
			end
			sct_pkg::LEX_VAR: begin
				if (!cur.name_seen) begin
					if (!eol && !cur.brace_open && c == sct_pkg::C_LBRACE) begin
						s.brace_open = 1'b1;
						done = 1'b1;
					end else if (!eol && cur.brace_open && c == sct_pkg::C_RBRACE) begin
						s.lex_mode = sct_pkg::LEX_WORD;
						s.brace_open = 1'b0;
						s.name_seen = 1'b0;
						s.part_open = 1'b0;
						done = 1'b1;
					end else if (!eol && sct_pkg::is_special(c)) begin
						r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_CHAR, sct_pkg::T_WORD,
							sct_pkg::P_VAR, cur.quote_mode, 1'b1, c));
						n = sct_pkg::bump(n);
						s.lex_mode = cur.brace_open ? sct_pkg::LEX_VCLOSE : sct_pkg::LEX_WORD;
						s.brace_open = 1'b0;
						s.name_seen = 1'b0;
						s.part_open = 1'b0;
						done = 1'b1;
					end else if (!eol && sct_pkg::is_name(c)) begin
						r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_CHAR, sct_pkg::T_WORD,
							sct_pkg::P_VAR, cur.quote_mode, 1'b1, c));
						n = sct_pkg::bump(n);
						s.name_seen = 1'b1;
						done = 1'b1;
					end else begin
						if (cur.brace_open) begin
							r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_ERROR, sct_pkg::T_WORD,
								2'd0, 2'd0, 1'b0, 8'd0));
						end else begin
							r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_CHAR, sct_pkg::T_WORD,
								sct_pkg::P_LIT, cur.quote_mode, 1'b1, sct_pkg::C_DOLLAR));
						end
						n = sct_pkg::bump(n);
						s.lex_mode = sct_pkg::LEX_WORD;
						s.brace_open = 1'b0;
						s.name_seen = 1'b0;
						s.part_open = 1'b0;
					end
				end else if (!eol && sct_pkg::is_name(c)) begin
					r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_CHAR, sct_pkg::T_WORD,
						sct_pkg::P_VAR, cur.quote_mode, 1'b0, c));
					n = sct_pkg::bump(n);
					done = 1'b1;
				end else begin
					if (cur.brace_open) begin
						if (!eol && c == sct_pkg::C_RBRACE) begin
							done = 1'b1;
						end else begin
							r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_ERROR, sct_pkg::T_WORD,
								2'd0, 2'd0, 1'b0, 8'd0));
							n = sct_pkg::bump(n);
						end
					end
					s.lex_mode = sct_pkg::LEX_WORD;
					s.brace_open = 1'b0;
					s.name_seen = 1'b0;
					s.part_open = 1'b0;
				end
			end
			sct_pkg::LEX_VCLOSE: begin
				s.lex_mode = sct_pkg::LEX_WORD;
				if (!eol && c == sct_pkg::C_RBRACE) begin
					done = 1'b1;
				end else begin
					r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_ERROR, sct_pkg::T_WORD,
						2'd0, 2'd0, 1'b0, 8'd0));
					n = sct_pkg::bump(n);
				end
			end
			sct_pkg::LEX_TILDE: begin
				if (!eol && sct_pkg::is_name(c)) begin
					r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_CHAR, sct_pkg::T_WORD,
						sct_pkg::P_TILDE, sct_pkg::Q_NONE, 1'b0, c));
					n = sct_pkg::bump(n);
					done = 1'b1;
				end else begin
					s.lex_mode = sct_pkg::LEX_WORD;
				end
			end
			default: begin
			end
		endcase

		if (!done) begin
			if (eol) begin
				if (s.in_word) begin
					r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_TOKEN,
						sct_pkg::word_tok(s.fd_check), 2'd0, 2'd0, 1'b0, 8'd0));
					n = sct_pkg::bump(n);
				end
				r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_TOKEN, sct_pkg::T_EOF,
					2'd0, 2'd0, 1'b0, 8'd0));
				n = sct_pkg::bump(n);
				s = sct_pkg::STATE_RESET;
			end else begin
				if (s.lex_mode == sct_pkg::LEX_WORD && s.quote_mode == sct_pkg::Q_NONE
					&& (sct_pkg::is_space(c) || sct_pkg::is_meta(c))) begin
					r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_TOKEN,
						sct_pkg::word_tok(s.fd_check), 2'd0, 2'd0, 1'b0, 8'd0));
					n = sct_pkg::bump(n);
					s = sct_pkg::STATE_RESET;
				end
				if (s.lex_mode == sct_pkg::LEX_WORD) begin
					do_word = 1'b1;
				end else if (sct_pkg::is_space(c)) begin
					do_word = 1'b0;
				end else if (c == sct_pkg::C_BAR || c == sct_pkg::C_AMP
					|| c == sct_pkg::C_GT) begin
					s.lex_mode = sct_pkg::LEX_OP;
					s.pending_op = (c == sct_pkg::C_BAR) ? sct_pkg::OP_PIPE :
						(c == sct_pkg::C_AMP) ? sct_pkg::OP_AMP : sct_pkg::OP_GT;
				end else if (c == sct_pkg::C_LT) begin
					r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_TOKEN, sct_pkg::T_IN,
						2'd0, 2'd0, 1'b0, 8'd0));
					n = sct_pkg::bump(n);
				end else if (c == sct_pkg::C_SEMI) begin
					r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_TOKEN, sct_pkg::T_SEMI,
						2'd0, 2'd0, 1'b0, 8'd0));
					n = sct_pkg::bump(n);
				end else begin
					s.in_word = 1'b1;
					s.lex_mode = sct_pkg::LEX_WORD;
					s.quote_mode = sct_pkg::Q_NONE;
					s.fd_check = sct_pkg::FD_START;
					s.part_open = 1'b0;
					do_word = 1'b1;
				end

				if (do_word) begin
					if (sct_pkg::is_digit(c)) begin
						s.fd_check = (s.fd_check == sct_pkg::FD_FAIL) ? sct_pkg::FD_FAIL :
							sct_pkg::FD_DIGITS;
					end else if ((c == sct_pkg::C_PLUS || c == sct_pkg::C_MINUS)
						&& s.fd_check == sct_pkg::FD_START) begin
						s.fd_check = sct_pkg::FD_SIGN;
					end else begin
						s.fd_check = sct_pkg::FD_FAIL;
					end
					priority if (s.quote_mode == sct_pkg::Q_SINGLE) begin
						if (c == sct_pkg::C_SQUOTE) begin
							s.quote_mode = sct_pkg::Q_NONE;
							s.part_open = 1'b0;
						end else begin
							r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_CHAR, sct_pkg::T_WORD,
								sct_pkg::P_LIT, s.quote_mode, !s.part_open, c));
							n = sct_pkg::bump(n);
							s.part_open = 1'b1;
						end
					end else if (s.quote_mode == sct_pkg::Q_DOUBLE && c == sct_pkg::C_DQUOTE) begin
						s.quote_mode = sct_pkg::Q_NONE;
						s.part_open = 1'b0;
					end else if (s.quote_mode == sct_pkg::Q_NONE && c == sct_pkg::C_SQUOTE) begin
						s.quote_mode = sct_pkg::Q_SINGLE;
						s.part_open = 1'b0;
					end else if (s.quote_mode == sct_pkg::Q_NONE && c == sct_pkg::C_DQUOTE) begin
						s.quote_mode = sct_pkg::Q_DOUBLE;
						s.part_open = 1'b0;
					end else if (c == sct_pkg::C_DOLLAR) begin
						s.lex_mode = sct_pkg::LEX_VAR;
						s.brace_open = 1'b0;
						s.name_seen = 1'b0;
					end else if (c == sct_pkg::C_BSLASH) begin
						s.lex_mode = sct_pkg::LEX_ESC;
					end else if (s.quote_mode == sct_pkg::Q_NONE && c == sct_pkg::C_TILDE) begin
						r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_CHAR, sct_pkg::T_WORD,
							sct_pkg::P_TILDE, sct_pkg::Q_NONE, 1'b1, c));
						n = sct_pkg::bump(n);
						s.part_open = 1'b0;
						s.lex_mode = sct_pkg::LEX_TILDE;
					end else if (s.quote_mode == sct_pkg::Q_NONE
						&& (c == sct_pkg::C_STAR || c == sct_pkg::C_QMARK)) begin
						r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_CHAR, sct_pkg::T_WORD,
							sct_pkg::P_GLOB, sct_pkg::Q_NONE, 1'b1, c));
						n = sct_pkg::bump(n);
						s.part_open = 1'b0;
					end else begin
						r = sct_pkg::put(r, n, sct_pkg::mk(sct_pkg::EV_CHAR, sct_pkg::T_WORD,
							sct_pkg::P_LIT, s.quote_mode, !s.part_open, c));
						n = sct_pkg::bump(n);
						s.part_open = 1'b1;
					end
				end
			end
		end

		if (n != 2'd0) begin
			r[n - 2'd1].last = 1'b1;
		end
		nxt = s;
		res = r;
		count = n;
	end

endmodule

### sv/sct_result_fifo.sv
`timescale 1ns / 1ps
module sct_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_n,
	input  sct_pkg::sct_res3_t  push_data,
	input  logic                pop,
	output logic                room,
	output logic                nonempty,
	output sct_pkg::sct_out_t   head,
	output logic [2:0]          level
);

	sct_pkg::sct_out_t mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < push_n) begin
				mem_q[wr_q + 2'(k)] <= push_data[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + push_n;
			rd_q <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	assign room = cnt_q <= 3'd1;
	assign nonempty = cnt_q != 3'd0;
	assign head = mem_q[rd_q];
	assign level = cnt_q;

endmodule

### sv/shell_command_tokenizer_unit.sv
`timescale 1ns / 1ps
// Shell command-line lexer. Takes one byte per src transfer and gives 0 to 3 result
// transfers per byte on res, each a word character, a finished token or a brace error.
// A byte is latched in an input register, decoded combinationally against the lexer
// state, and its results are written into a four-entry result queue that feeds res; a
// byte can be taken every cycle while the queue has room. The res port moves one result
// per cycle while res_stall is low, so the results of a byte leave in turn, and src
// stalls only while the queue lacks room for three more results.
`include "assert_macros.svh"
module shell_command_tokenizer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  sct_pkg::sct_in_t   src_item,
	output logic               res_valid,
	input  logic               res_stall,
	output sct_pkg::sct_out_t  res_item
);

	logic valid_s1;
	sct_pkg::sct_in_t item_s1;
	sct_pkg::sct_state_t state_q;
	sct_pkg::sct_state_t state_nxt;
	sct_pkg::sct_res3_t res;
	logic [1:0] cnt;
	logic room;
	logic proc;
	logic pop;
	logic [2:0] level;

	sct_step u_step (
		.item  (item_s1),
		.cur   (state_q),
		.nxt   (state_nxt),
		.res   (res),
		.count (cnt)
	);

	sct_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (proc ? cnt : 2'd0),
		.push_data (res),
		.pop       (pop),
		.room      (room),
		.nonempty  (res_valid),
		.head      (res_item),
		.level     (level)
	);

	assign proc = valid_s1 && room;
	assign src_stall = valid_s1 && !room;
	assign pop = res_valid && !res_stall;

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q <= sct_pkg::STATE_RESET;
		end else begin
			if (src_valid && !src_stall) begin
				valid_s1 <= 1'b1;
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end
			if (proc) begin
				state_q <= state_nxt;
			end
		end
	end

	`SCT_ASSERT_ALWAYS(a_level_bound, level <= 3'd4, "result queue overflow")
	`SCT_ASSERT(a_stall_when_full, (valid_s1 && level > 3'd1) |-> src_stall,
		"src not stalled with queue full")
	`SCT_ASSERT(a_eof_resets, (proc && !item_s1.is_end && item_s1.ch == 8'h00)
		|=> (state_q == sct_pkg::STATE_RESET), "state not reset after end of line")

endmodule

### dv/tb_shell_command_tokenizer_unit.sv
`timescale 1ns / 1ps
module tb_shell_command_tokenizer_unit;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	sct_pkg::sct_in_t src_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	sct_pkg::sct_out_t res_item;

	shell_command_tokenizer_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src_item(src_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
	);

	always #10 clk = ~clk;

	sct_pkg::sct_out_t token_q[$];
	sct_pkg::sct_out_t step_q[$];
	int errors = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int src_idle_pct = 0;
	int res_idle_pct = 0;
	int hold_cycles = 0;
	longint cycle_cnt = 0;

	sct_pkg::sct_lex_t lm;
	logic [1:0] qm, pop, fdc;
	logic bo, ns, po, iw;

	string frags[] = '{"ls", "-1", "+7", "42", "$x", "${ab}", "${}", "$?", "${!}", "${q",
		"~u", "*", "?", "'s q'", "\"d $v\"", "\\t", "\\", "|", "||", "&", "&&", ">", ">>",
		"<", ";", " ", "\t", "$", "{", "}", "'", "\"", "${-", "$$", "a_9"};

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_cnt, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		sct_pkg::sct_out_t e;
		if (res_valid && !res_stall) begin
			results_seen++;
			if (token_q.size() == 0) begin
				report($sformatf("unexpected result %p", res_item));
			end else begin
				e = token_q.pop_front();
				if (res_item.event_res !== e.event_res) report($sformatf("event_res %0d exp %0d",
					res_item.event_res, e.event_res));
				if (res_item.token_type !== e.token_type) report($sformatf("token_type %0d exp %0d",
					res_item.token_type, e.token_type));
				if (res_item.part_type !== e.part_type) report($sformatf("part_type %0d exp %0d",
					res_item.part_type, e.part_type));
				if (res_item.quote !== e.quote) report($sformatf("quote %0d exp %0d",
					res_item.quote, e.quote));
				if (res_item.part_start !== e.part_start) report($sformatf("part_start %0d exp %0d",
					res_item.part_start, e.part_start));
				if (res_item.value !== e.value) report($sformatf("value %h exp %h",
					res_item.value, e.value));
				if (res_item.last !== e.last) report($sformatf("last %0d exp %0d",
					res_item.last, e.last));
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < res_idle_pct);
		end
	end

	function automatic bit c_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit c_name(input logic [7:0] c);
		return c_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
			|| c == sct_pkg::C_UNDER;
	endfunction

	function automatic bit c_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit c_meta(input logic [7:0] c);
		return c == sct_pkg::C_BAR || c == sct_pkg::C_AMP || c == sct_pkg::C_SEMI
			|| c == sct_pkg::C_LT || c == sct_pkg::C_GT;
	endfunction

	function automatic bit c_special(input logic [7:0] c);
		return c == sct_pkg::C_DOLLAR || c == sct_pkg::C_QMARK || c == sct_pkg::C_BANG
			|| c == sct_pkg::C_MINUS;
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] c);
		case (c)
			"n": return 8'd10;
			"t": return 8'd9;
			"r": return 8'd13;
			"a": return 8'd7;
			"b": return 8'd8;
			"f": return 8'd12;
			"v": return 8'd11;
			default: return c;
		endcase
	endfunction

	task automatic clear_lexer();
		lm = sct_pkg::LEX_IDLE; qm = sct_pkg::Q_NONE; pop = sct_pkg::OP_NONE; bo = 0; ns = 0;
		fdc = sct_pkg::FD_START; po = 0; iw = 0;
	endtask

	task automatic emit(input logic [1:0] ev, input logic [3:0] tok, input logic [1:0] pt,
		input logic [1:0] q, input logic ps, input logic [7:0] val);
		sct_pkg::sct_out_t o;
		o.event_res = ev; o.token_type = tok; o.part_type = pt; o.quote = q;
		o.part_start = ps; o.value = val; o.last = 1'b0;
		if (step_q.size() < 3) step_q.push_back(o);
	endtask

	task automatic emit_tok(input logic [3:0] tok);
		emit(sct_pkg::EV_TOKEN, tok, sct_pkg::P_LIT, sct_pkg::Q_NONE, 1'b0, 8'd0);
	endtask

	task automatic emit_err();
		emit(sct_pkg::EV_ERROR, sct_pkg::T_WORD, sct_pkg::P_LIT, sct_pkg::Q_NONE, 1'b0, 8'd0);
	endtask

	task automatic emit_lit(input logic [7:0] c);
		emit(sct_pkg::EV_CHAR, sct_pkg::T_WORD, sct_pkg::P_LIT, qm, !po, c);
		po = 1;
	endtask

	task automatic word_byte(input logic [7:0] c);
		if (c_digit(c)) fdc = (fdc == sct_pkg::FD_FAIL) ? sct_pkg::FD_FAIL : sct_pkg::FD_DIGITS;
		else if ((c == sct_pkg::C_PLUS || c == sct_pkg::C_MINUS) && fdc == sct_pkg::FD_START)
			fdc = sct_pkg::FD_SIGN;
		else fdc = sct_pkg::FD_FAIL;
		if (qm == sct_pkg::Q_SINGLE) begin
			if (c == sct_pkg::C_SQUOTE) begin
				qm = sct_pkg::Q_NONE; po = 0;
			end else emit_lit(c);
		end else if (qm == sct_pkg::Q_DOUBLE && c == sct_pkg::C_DQUOTE) begin
			qm = sct_pkg::Q_NONE; po = 0;
		end else if (qm == sct_pkg::Q_NONE && c == sct_pkg::C_SQUOTE) begin
			qm = sct_pkg::Q_SINGLE; po = 0;
		end else if (qm == sct_pkg::Q_NONE && c == sct_pkg::C_DQUOTE) begin
			qm = sct_pkg::Q_DOUBLE; po = 0;
		end else if (c == sct_pkg::C_DOLLAR) begin
			lm = sct_pkg::LEX_VAR; bo = 0; ns = 0;
		end else if (c == sct_pkg::C_BSLASH) begin
			lm = sct_pkg::LEX_ESC;
		end else if (qm == sct_pkg::Q_NONE && c == sct_pkg::C_TILDE) begin
			emit(sct_pkg::EV_CHAR, sct_pkg::T_WORD, sct_pkg::P_TILDE, sct_pkg::Q_NONE, 1'b1, c);
			po = 0; lm = sct_pkg::LEX_TILDE;
		end else if (qm == sct_pkg::Q_NONE
			&& (c == sct_pkg::C_STAR || c == sct_pkg::C_QMARK)) begin
			emit(sct_pkg::EV_CHAR, sct_pkg::T_WORD, sct_pkg::P_GLOB, sct_pkg::Q_NONE, 1'b1, c);
			po = 0;
		end else emit_lit(c);
	endtask

	task automatic close_var();
		lm = sct_pkg::LEX_WORD; bo = 0; ns = 0; po = 0;
	endtask

	task automatic finish_pending(input logic [7:0] c, input bit e, output bit used);
		logic [1:0] op;
		used = 0;
		case (lm)
			sct_pkg::LEX_OP: begin
				op = pop;
				lm = sct_pkg::LEX_IDLE; pop = sct_pkg::OP_NONE;
				if (!e && ((op == sct_pkg::OP_PIPE && c == sct_pkg::C_BAR)
					|| (op == sct_pkg::OP_AMP && c == sct_pkg::C_AMP)
					|| (op == sct_pkg::OP_GT && c == sct_pkg::C_GT))) begin
					emit_tok(op == sct_pkg::OP_PIPE ? sct_pkg::T_OR :
						op == sct_pkg::OP_AMP ? sct_pkg::T_AND : sct_pkg::T_APPEND);
					used = 1;
				end else begin
					emit_tok(op == sct_pkg::OP_PIPE ? sct_pkg::T_PIPE :
						op == sct_pkg::OP_AMP ? sct_pkg::T_BG : sct_pkg::T_OUT);
				end
			end
			sct_pkg::LEX_ESC: begin
				lm = sct_pkg::LEX_WORD;
				if (!e) begin
					emit_lit(unescape(c)); used = 1;
				end
			end
			sct_pkg::LEX_VAR: begin
				if (!ns) begin
					if (!e && !bo && c == sct_pkg::C_LBRACE) begin
						bo = 1; used = 1;
					end else if (!e && bo && c == sct_pkg::C_RBRACE) begin
						close_var(); used = 1;
					end else if (!e && c_special(c)) begin
						emit(sct_pkg::EV_CHAR, sct_pkg::T_WORD, sct_pkg::P_VAR, qm, 1'b1, c);
						if (bo) begin
							lm = sct_pkg::LEX_VCLOSE; bo = 0; po = 0;
						end else close_var();
						used = 1;
					end else if (!e && c_name(c)) begin
						emit(sct_pkg::EV_CHAR, sct_pkg::T_WORD, sct_pkg::P_VAR, qm, 1'b1, c);
						ns = 1; used = 1;
					end else begin
						if (bo) emit_err();
						else emit(sct_pkg::EV_CHAR, sct_pkg::T_WORD, sct_pkg::P_LIT, qm, 1'b1,
							sct_pkg::C_DOLLAR);
						close_var();
					end
				end else if (!e && c_name(c)) begin
					emit(sct_pkg::EV_CHAR, sct_pkg::T_WORD, sct_pkg::P_VAR, qm, 1'b0, c);
					used = 1;
				end else if (bo && !e && c == sct_pkg::C_RBRACE) begin
					close_var(); used = 1;
				end else begin
					if (bo) emit_err();
					close_var();
				end
			end
			sct_pkg::LEX_VCLOSE: begin
				lm = sct_pkg::LEX_WORD;
				if (!e && c == sct_pkg::C_RBRACE) used = 1;
				else emit_err();
			end
			sct_pkg::LEX_TILDE: begin
				if (!e && c_name(c)) begin
					emit(sct_pkg::EV_CHAR, sct_pkg::T_WORD, sct_pkg::P_TILDE, sct_pkg::Q_NONE,
						1'b0, c);
					used = 1;
				end else lm = sct_pkg::LEX_WORD;
			end
			default: used = 0;
		endcase
	endtask

	task automatic lex_byte(input sct_pkg::sct_in_t it);
		bit e, used;
		logic [7:0] c;
		c = it.ch;
		e = it.is_end || c == 8'd0;
		step_q.delete();
		finish_pending(c, e, used);
		if (!used) begin
			if (e) begin
				if (iw) emit_tok(fdc == sct_pkg::FD_DIGITS ? sct_pkg::T_FD : sct_pkg::T_WORD);
				emit_tok(sct_pkg::T_EOF);
				clear_lexer();
			end else begin
				if (lm == sct_pkg::LEX_WORD && qm == sct_pkg::Q_NONE
					&& (c_space(c) || c_meta(c))) begin
					emit_tok(fdc == sct_pkg::FD_DIGITS ? sct_pkg::T_FD : sct_pkg::T_WORD);
					clear_lexer();
				end
				if (lm == sct_pkg::LEX_WORD) word_byte(c);
				else if (c_space(c)) begin
				end else if (c == sct_pkg::C_BAR || c == sct_pkg::C_AMP
					|| c == sct_pkg::C_GT) begin
					lm = sct_pkg::LEX_OP;
					pop = (c == sct_pkg::C_BAR) ? sct_pkg::OP_PIPE :
						(c == sct_pkg::C_AMP) ? sct_pkg::OP_AMP : sct_pkg::OP_GT;
				end else if (c == sct_pkg::C_LT) emit_tok(sct_pkg::T_IN);
				else if (c == sct_pkg::C_SEMI) emit_tok(sct_pkg::T_SEMI);
				else begin
					iw = 1; lm = sct_pkg::LEX_WORD; qm = sct_pkg::Q_NONE;
					fdc = sct_pkg::FD_START; po = 0;
					word_byte(c);
				end
			end
		end
		if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i]) token_q.push_back(step_q[i]);
	endtask

	task automatic send_byte(input logic [7:0] c, input logic e);
		sct_pkg::sct_in_t it;
		it.ch = c; it.is_end = e;
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item <= it;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		lex_byte(it);
		bytes_sent++;
	endtask

	task automatic send_line(input string s, input bit zero_end);
		foreach (s[i]) send_byte(s[i], 1'b0);
		if (zero_end) send_byte(8'd0, 1'b0);
		else send_byte(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic drain();
		src_valid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_directed();
		send_line("a|b||c&&d&>e>>f<g;", 1'b0);
		send_line("'x\"$y' \"a'$HOME\" ${} $ ${ab ${-} ${?x", 1'b1);
		send_line("~root/* ? \\n\\q +12 -3 '' \\", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_line("\"open", 1'b1);
		drain();
	endtask

	task automatic random_line();
		string s;
		int n;
		s = "";
		n = $urandom_range(1, 7);
		repeat (n) begin
			if ($urandom_range(9) == 0) s = {s, string'(byte'($urandom_range(1, 255)))};
			else s = {s, frags[$urandom_range(frags.size() - 1)]};
		end
		send_line(s, $urandom_range(3) == 0);
	endtask

	task automatic test_random(input int src_pct, input int res_pct, input int n_bytes);
		int stop_at;
		src_idle_pct = src_pct;
		res_idle_pct = res_pct;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
			else random_line();
		end
		drain();
	endtask

	task automatic test_backpressure();
		src_idle_pct = 0;
		res_idle_pct = 0;
		hold_cycles = 150;
		repeat (3) random_line();
		src_valid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
		send_line("x${y} ~z", 1'b0);
		drain();
	endtask

	initial begin
		clear_lexer();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(13, 71, 100);
		test_random(71, 13, 100);
		test_random(0, 0, 100);
		test_backpressure();
		$display("covered %0d bytes and %0d results: operators, quotes, variables, escapes,",
			bytes_sent, results_seen);
		$display("tilde, globs, fd words, brace errors, under both idle mixes and a long stall");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
